FILE: rtl/core/sws_pkg.sv
// ============================================================================
// String wave stencil package
// Shared types, field widths and codes for the string wave stencil block.
// ============================================================================
package sws_pkg;

    localparam int RATIO_W     = 32;
    localparam int POINTS_W    = 8;
    localparam int VALUE_W     = 32;
    localparam int INDEX_W     = 7;
    localparam int KIND_W      = 2;
    localparam int PADDR_W     = 3;
    localparam int PDATA_W     = 32;
    localparam int NUM_BANKS   = 3;
    localparam int MIN_POINTS  = 3;
    localparam int FIRST_SHIFT = 25;
    localparam int STEP_SHIFT  = 24;

    localparam logic [KIND_W-1:0] KIND_LOAD    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ADVANCE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_READ    = 2'd2;

    localparam logic REG_RATIO  = 1'b0;
    localparam logic REG_POINTS = 1'b1;

    localparam logic [RATIO_W-1:0]  RATIO_RESET  = 32'd16777216;
    localparam logic [POINTS_W-1:0] POINTS_RESET = 8'd128;

    typedef logic [1:0] bank_sel_t;

    localparam bank_sel_t BANK_A = 2'd0;
    localparam bank_sel_t BANK_B = 2'd1;
    localparam bank_sel_t BANK_C = 2'd2;

    typedef struct packed {
        logic [KIND_W-1:0]         kind;
        logic [INDEX_W-1:0]        point_index;
        logic signed [VALUE_W-1:0] load_value;
    } item_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] displacement;
        logic                      saturated;
    } result_t;

    typedef struct packed {
        logic take_item;
        logic clear_step;
        logic load_write;
        logic read_issue;
        logic out_load;
        logic zero_lo;
        logic zero_hi;
        logic sweep_start;
        logic sweep_issue;
        logic adv_finish;
    } ctrl_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic sweep_last;
        logic pipe_busy;
        logic out_busy;
    } ctrl_status_t;

endpackage

FILE: rtl/core/sws_ram.sv
// ============================================================================
// String wave stencil row memory
// Simple dual-port RAM with one write port and one registered read port.
// ============================================================================
module sws_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: rtl/core/sws_ctrl.sv
// ============================================================================
// String wave stencil controller
// Sequences the clearing pass, loads, reads and the advance sweep.
// ============================================================================
module sws_ctrl (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              item_valid,
    input  logic [sws_pkg::KIND_W-1:0]        item_kind,
    output logic                              item_stall,
    output sws_pkg::ctrl_cmd_t                cmd,
    input  sws_pkg::ctrl_status_t             status
);

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOAD,
        ST_RD_ISSUE,
        ST_RD_WAIT,
        ST_ZERO_LO,
        ST_ZERO_HI,
        ST_SWEEP,
        ST_DRAIN
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   stall_reg;
    logic   accept;

    assign item_stall = stall_reg;
    assign accept     = (state_reg == ST_IDLE) && item_valid && !stall_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (status.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd.take_item = 1'b1;
                    unique case (item_kind)
                        sws_pkg::KIND_LOAD:    state_next = ST_LOAD;
                        sws_pkg::KIND_ADVANCE: state_next = ST_ZERO_LO;
                        sws_pkg::KIND_READ:    state_next = ST_RD_ISSUE;
                        default:               state_next = ST_IDLE;
                    endcase
                end
            end
            ST_LOAD:
            begin
                cmd.load_write = 1'b1;
                state_next     = ST_IDLE;
            end
            ST_RD_ISSUE:
            begin
                cmd.read_issue = 1'b1;
                state_next     = ST_RD_WAIT;
            end
            ST_RD_WAIT:
            begin
                if (!status.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_ZERO_LO:
            begin
                cmd.zero_lo = 1'b1;
                state_next  = ST_ZERO_HI;
            end
            ST_ZERO_HI:
            begin
                cmd.zero_hi     = 1'b1;
                cmd.sweep_start = 1'b1;
                state_next      = ST_SWEEP;
            end
            ST_SWEEP:
            begin
                cmd.sweep_issue = 1'b1;
                if (status.sweep_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!status.pipe_busy)
                begin
                    cmd.adv_finish = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            stall_reg <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            stall_reg <= (state_next != ST_IDLE);
        end
    end

endmodule

FILE: rtl/core/sws_datapath.sv
// ============================================================================
// String wave stencil datapath
// Three row banks with rotating roles, the stencil window and the
// multiply, round and saturate pipeline, plus the result register.
// ============================================================================
module sws_datapath #(
    parameter int MAX_POINTS = 128
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  sws_pkg::ctrl_cmd_t             cmd,
    output sws_pkg::ctrl_status_t          status,
    input  sws_pkg::item_t                 item,
    input  logic [sws_pkg::RATIO_W-1:0]    wave_ratio,
    input  logic [sws_pkg::POINTS_W-1:0]   points_in_use,
    output logic                           result_valid,
    input  logic                           result_stall,
    output sws_pkg::result_t               result
);

    localparam int AW       = $clog2(MAX_POINTS);
    localparam int CW       = $clog2(MAX_POINTS + 1);
    localparam int VW       = sws_pkg::VALUE_W;
    localparam int IW       = sws_pkg::INDEX_W;
    localparam int NB       = sws_pkg::NUM_BANKS;
    localparam int BASE_W   = VW + 2;
    localparam int LAP_W    = VW + 3;
    localparam int HALF_W   = sws_pkg::RATIO_W / 2;
    localparam int PART_W   = LAP_W + HALF_W + 1;
    localparam int PROD_W   = LAP_W + sws_pkg::RATIO_W + 1;
    localparam int SCALED_W = PROD_W - sws_pkg::STEP_SHIFT;
    localparam int TOTAL_W  = SCALED_W + 2;

    localparam logic [PROD_W-1:0] RND_STEP  = PROD_W'(1) << (sws_pkg::STEP_SHIFT - 1);
    localparam logic [PROD_W-1:0] RND_FIRST = PROD_W'(1) << (sws_pkg::FIRST_SHIFT - 1);

    // Point count and end address
    logic [CW-1:0] count;
    logic [AW-1:0] last_addr;

    // Role state
    logic               started_reg;
    logic               overflow_reg;
    sws_pkg::bank_sel_t prev_sel_reg;
    sws_pkg::bank_sel_t cur_sel_reg;
    sws_pkg::bank_sel_t next_sel_reg;
    sws_pkg::bank_sel_t stream_sel;
    sws_pkg::bank_sel_t dest_sel;

    // Latched item
    logic [IW-1:0]        item_idx_reg;
    logic signed [VW-1:0] item_value_reg;
    logic                 idx_in_range;
    logic                 idx_at_end;
    logic [AW-1:0]        item_addr;

    // Counters
    logic [AW-1:0] clear_cnt_reg;
    logic [AW-1:0] k_reg;
    logic [AW-1:0] k_prev;

    // Banks
    logic          bank_we    [NB];
    logic [AW-1:0] bank_waddr [NB];
    logic [VW-1:0] bank_wdata [NB];
    logic          bank_re    [NB];
    logic [AW-1:0] bank_raddr [NB];
    logic [VW-1:0] bank_rdata [NB];

    // Pipeline
    logic                     iss_v_reg;
    logic [AW-1:0]            iss_k_reg;
    logic signed [VW-1:0]     stream_data;
    logic signed [VW-1:0]     old_data;
    logic signed [VW-1:0]     win_m1_reg;
    logic signed [VW-1:0]     win_m2_reg;
    logic signed [LAP_W-1:0]  lap_next;
    logic signed [BASE_W-1:0] base_next;

    logic                     s1_v_reg;
    logic [AW-1:0]            s1_j_reg;
    logic signed [LAP_W-1:0]  lap_reg;
    logic signed [BASE_W-1:0] s1_base_reg;

    logic signed [HALF_W:0]   ratio_hi;
    logic signed [HALF_W:0]   ratio_lo;
    logic                     s2_v_reg;
    logic [AW-1:0]            s2_j_reg;
    logic signed [PART_W-1:0] ph_reg;
    logic signed [PART_W-1:0] pl_reg;
    logic signed [BASE_W-1:0] s2_base_reg;

    logic signed [PROD_W-1:0]   prod_sum;
    logic signed [SCALED_W-1:0] scaled_next;
    logic                       s3_v_reg;
    logic [AW-1:0]              s3_j_reg;
    logic signed [SCALED_W-1:0] scaled_reg;
    logic signed [BASE_W-1:0]   s3_base_reg;

    logic signed [TOTAL_W-1:0] total;
    logic                      sat_hit;
    logic [VW-1:0]             sat_value;

    // Result register
    logic             out_valid_reg;
    sws_pkg::result_t out_reg;

    always_comb
    begin
        if (points_in_use < sws_pkg::POINTS_W'(sws_pkg::MIN_POINTS))
        begin
            count = CW'(sws_pkg::MIN_POINTS);
        end
        else if (int'(points_in_use) > MAX_POINTS)
        begin
            count = CW'(MAX_POINTS);
        end
        else
        begin
            count = CW'(points_in_use);
        end
    end

    assign last_addr    = AW'(count - CW'(1));
    assign stream_sel   = started_reg ? cur_sel_reg : prev_sel_reg;
    assign dest_sel     = started_reg ? next_sel_reg : cur_sel_reg;
    assign item_addr    = AW'(item_idx_reg);
    assign idx_in_range = int'(item_idx_reg) < int'(count);
    assign idx_at_end   = (item_addr == '0) || (item_addr == last_addr);
    assign k_prev       = (k_reg == '0) ? '0 : (k_reg - AW'(1));

    always_comb
    begin
        for (int b = 0; b < NB; b++)
        begin
            bank_we[b]    = 1'b0;
            bank_waddr[b] = '0;
            bank_wdata[b] = '0;
            bank_re[b]    = 1'b0;
            bank_raddr[b] = '0;
            if (cmd.clear_step && (int'(prev_sel_reg) == b))
            begin
                bank_we[b]    = 1'b1;
                bank_waddr[b] = clear_cnt_reg;
            end
            else if (cmd.load_write && idx_in_range && (int'(prev_sel_reg) == b))
            begin
                bank_we[b]    = 1'b1;
                bank_waddr[b] = item_addr;
                bank_wdata[b] = idx_at_end ? '0 : item_value_reg;
            end
            else if (cmd.zero_lo)
            begin
                bank_we[b] = 1'b1;
            end
            else if (cmd.zero_hi)
            begin
                bank_we[b]    = 1'b1;
                bank_waddr[b] = last_addr;
            end
            else if (s3_v_reg && (int'(dest_sel) == b))
            begin
                bank_we[b]    = 1'b1;
                bank_waddr[b] = s3_j_reg;
                bank_wdata[b] = sat_value;
            end

            if (cmd.sweep_issue && (int'(stream_sel) == b))
            begin
                bank_re[b]    = 1'b1;
                bank_raddr[b] = k_reg;
            end
            else if (cmd.sweep_issue && started_reg && (int'(prev_sel_reg) == b))
            begin
                bank_re[b]    = 1'b1;
                bank_raddr[b] = k_prev;
            end
            else if (cmd.read_issue && (int'(stream_sel) == b))
            begin
                bank_re[b]    = 1'b1;
                bank_raddr[b] = item_addr;
            end
        end
    end

    for (genvar g = 0; g < NB; g++)
    begin : g_bank
        sws_ram #(
            .WIDTH(VW),
            .DEPTH(MAX_POINTS)
        ) u_ram (
            .clk   (clk),
            .we    (bank_we[g]),
            .waddr (bank_waddr[g]),
            .wdata (bank_wdata[g]),
            .re    (bank_re[g]),
            .raddr (bank_raddr[g]),
            .rdata (bank_rdata[g])
        );
    end

    // Stencil window: the center point is the one before the newest sample.
    assign stream_data = $signed(bank_rdata[stream_sel]);
    assign old_data    = $signed(bank_rdata[prev_sel_reg]);

    always_comb
    begin
        lap_next = LAP_W'(stream_data) + LAP_W'(win_m2_reg) - (LAP_W'(win_m1_reg) <<< 1);
        if (started_reg)
        begin
            base_next = (BASE_W'(win_m1_reg) <<< 1) - BASE_W'(old_data);
        end
        else
        begin
            base_next = BASE_W'(win_m1_reg);
        end
    end

    assign ratio_hi = $signed({1'b0, wave_ratio[sws_pkg::RATIO_W-1:HALF_W]});
    assign ratio_lo = $signed({1'b0, wave_ratio[HALF_W-1:0]});

    always_comb
    begin
        prod_sum = (PROD_W'(ph_reg) <<< HALF_W) + PROD_W'(pl_reg)
                 + (started_reg ? $signed(RND_STEP) : $signed(RND_FIRST));
        if (started_reg)
        begin
            scaled_next = SCALED_W'(prod_sum >>> sws_pkg::STEP_SHIFT);
        end
        else
        begin
            scaled_next = SCALED_W'(prod_sum >>> sws_pkg::FIRST_SHIFT);
        end
    end

    always_comb
    begin
        total   = TOTAL_W'(s3_base_reg) + TOTAL_W'(scaled_reg);
        sat_hit = !((&total[TOTAL_W-1:VW-1]) || !(|total[TOTAL_W-1:VW-1]));
        if (!sat_hit)
        begin
            sat_value = total[VW-1:0];
        end
        else if (total[TOTAL_W-1])
        begin
            sat_value = {1'b1, {(VW-1){1'b0}}};
        end
        else
        begin
            sat_value = {1'b0, {(VW-1){1'b1}}};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            started_reg   <= 1'b0;
            overflow_reg  <= 1'b0;
            prev_sel_reg  <= sws_pkg::BANK_A;
            cur_sel_reg   <= sws_pkg::BANK_B;
            next_sel_reg  <= sws_pkg::BANK_C;
            clear_cnt_reg <= '0;
            k_reg         <= '0;
            iss_v_reg     <= 1'b0;
            s1_v_reg      <= 1'b0;
            s2_v_reg      <= 1'b0;
            s3_v_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clear_step)
            begin
                clear_cnt_reg <= clear_cnt_reg + AW'(1);
            end

            if (cmd.sweep_start)
            begin
                k_reg <= '0;
            end
            else if (cmd.sweep_issue)
            begin
                k_reg <= k_reg + AW'(1);
            end

            iss_v_reg <= cmd.sweep_issue;
            s1_v_reg  <= iss_v_reg && (iss_k_reg >= AW'(2));
            s2_v_reg  <= s1_v_reg;
            s3_v_reg  <= s2_v_reg;

            if (cmd.load_write)
            begin
                started_reg  <= 1'b0;
                overflow_reg <= 1'b0;
            end
            else if (cmd.adv_finish)
            begin
                started_reg <= 1'b1;
                if (started_reg)
                begin
                    prev_sel_reg <= cur_sel_reg;
                    cur_sel_reg  <= next_sel_reg;
                    next_sel_reg <= prev_sel_reg;
                end
            end
            else if (s3_v_reg && sat_hit)
            begin
                overflow_reg <= 1'b1;
            end

            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !result_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take_item)
        begin
            item_idx_reg   <= item.point_index;
            item_value_reg <= item.load_value;
        end

        iss_k_reg <= k_reg;
        if (iss_v_reg)
        begin
            win_m1_reg <= stream_data;
            win_m2_reg <= win_m1_reg;
        end

        s1_j_reg    <= iss_k_reg - AW'(1);
        lap_reg     <= lap_next;
        s1_base_reg <= base_next;

        s2_j_reg    <= s1_j_reg;
        ph_reg      <= lap_reg * ratio_hi;
        pl_reg      <= lap_reg * ratio_lo;
        s2_base_reg <= s1_base_reg;

        s3_j_reg    <= s2_j_reg;
        scaled_reg  <= scaled_next;
        s3_base_reg <= s2_base_reg;

        if (cmd.out_load)
        begin
            out_reg.displacement <= idx_in_range ? stream_data : '0;
            out_reg.saturated    <= overflow_reg;
        end
    end

    assign status.clear_last = (clear_cnt_reg == AW'(MAX_POINTS - 1));
    assign status.sweep_last = (k_reg == last_addr);
    assign status.pipe_busy  = iss_v_reg || s1_v_reg || s2_v_reg || s3_v_reg;
    assign status.out_busy   = out_valid_reg && result_stall;

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

FILE: rtl/core/string_wave_stencil_step.sv
// ============================================================================
// String wave stencil step: 1-D wave equation with fixed ends, Q8.24 rows.
// A load writes an in-range point; a read waits for a free result register.
// An advance sweeps one point per cycle through one multiply pipe.
// After reset every address of the previous row is cleared before items are taken.
// ============================================================================
module string_wave_stencil_step #(
    parameter int MAX_POINTS = 128
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           item_valid,
    output logic                           item_stall,
    input  sws_pkg::item_t                 item,
    output logic                           result_valid,
    input  logic                           result_stall,
    output sws_pkg::result_t               result,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [sws_pkg::PADDR_W-1:0]    paddr,
    input  logic [sws_pkg::PDATA_W-1:0]    pwdata,
    output logic [sws_pkg::PDATA_W-1:0]    prdata,
    output logic                           pready
);

    logic [sws_pkg::RATIO_W-1:0]  wave_ratio_reg;
    logic [sws_pkg::POINTS_W-1:0] points_reg;
    logic                         cfg_write;
    sws_pkg::ctrl_cmd_t           cmd;
    sws_pkg::ctrl_status_t        status;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wave_ratio_reg <= sws_pkg::RATIO_RESET;
            points_reg     <= sws_pkg::POINTS_RESET;
        end
        else if (cfg_write)
        begin
            unique case (paddr[2])
                sws_pkg::REG_RATIO:  wave_ratio_reg <= pwdata;
                sws_pkg::REG_POINTS: points_reg     <= pwdata[sws_pkg::POINTS_W-1:0];
                default:             wave_ratio_reg <= wave_ratio_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            sws_pkg::REG_RATIO:  prdata = wave_ratio_reg;
            sws_pkg::REG_POINTS: prdata = sws_pkg::PDATA_W'(points_reg);
            default:             prdata = '0;
        endcase
    end

    sws_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_kind  (item.kind),
        .item_stall (item_stall),
        .cmd        (cmd),
        .status     (status)
    );

    sws_datapath #(
        .MAX_POINTS(MAX_POINTS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .item          (item),
        .wave_ratio    (wave_ratio_reg),
        .points_in_use (points_reg),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .result        (result)
    );

endmodule

FILE: rtl/core/sws_checker.sv
// ============================================================================
// String wave stencil checker
// Port-level properties of the string wave stencil step, bound to the top.
// ============================================================================
module sws_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        item_valid,
    input logic                        item_stall,
    input sws_pkg::item_t              item,
    input logic                        result_valid,
    input logic                        result_stall,
    input sws_pkg::result_t            result,
    input logic                        psel,
    input logic                        penable,
    input logic                        pwrite,
    input logic [sws_pkg::PADDR_W-1:0] paddr,
    input logic [sws_pkg::PDATA_W-1:0] pwdata,
    input logic [sws_pkg::PDATA_W-1:0] prdata,
    input logic                        pready
);

    // A stalled result transaction holds its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
    else $error("result changed while stalled");

    // Every accepted load, advance or read item is followed by a stalled input.
    assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall
        && (item.kind == sws_pkg::KIND_LOAD || item.kind == sws_pkg::KIND_ADVANCE
            || item.kind == sws_pkg::KIND_READ)
        |=> item_stall)
    else $error("input not stalled after an accepted item");

    // A new result only appears while the input side is held off.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(item_stall))
    else $error("result appeared while the block was idle");

    // A written ratio reads back in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (psel && penable && pwrite && pready && paddr[2] == sws_pkg::REG_RATIO)
        ##1 (psel && !pwrite && paddr[2] == sws_pkg::REG_RATIO)
        |-> prdata == $past(pwdata))
    else $error("ratio register readback mismatch");

endmodule

bind string_wave_stencil_step sws_checker u_checker (.*);
